// ===== hdl/rpwd_pkg.sv =====
// Shared constants, types and register codes for the RC pulse width decoder.
`timescale 1ns / 1ps
`default_nettype none

package rpwd_pkg;

    localparam int unsigned PULSE_MIN = 1000;
    localparam int unsigned PULSE_MAX = 2000;

    localparam int unsigned TICK_W      = 32;
    localparam int unsigned DUTY_W      = 16;
    localparam int unsigned CFG_DATA_W  = 32;

    // Degenerate pulse range: every falling edge reports max_duty.
    localparam bit          PULSE_DEGEN = (PULSE_MAX <= PULSE_MIN);
    localparam int unsigned PULSE_RANGE = PULSE_DEGEN ? 1 : (PULSE_MAX - PULSE_MIN);

    // Clamped offset width, product width and reciprocal for the divide by range.
    localparam int unsigned OFF_W   = $clog2(PULSE_RANGE + 1);
    localparam int unsigned PROD_W  = OFF_W + DUTY_W;
    localparam longint unsigned RECIP = (64'd1 << PROD_W) / PULSE_RANGE;
    localparam int unsigned RECIP_W = $clog2(RECIP + 1);

    localparam logic [TICK_W-1:0] PULSE_MIN_T = TICK_W'(PULSE_MIN);
    localparam logic [TICK_W-1:0] PULSE_MAX_T = TICK_W'(PULSE_MAX);

    localparam logic [DUTY_W-1:0] MAX_DUTY_RST      = 16'd1023;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 32'd1000000;

    // Output queue; covers the words in flight so ready can come from a register.
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [0:0] {
        CFG_MAX_DUTY      = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic              duty_valid;
        logic [DUTY_W-1:0] duty_value;
        logic [TICK_W-1:0] pulse_width;
        logic              timed_out;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/rpwd_intf.sv =====
// Valid/ready channel interfaces: pin sample input, result output, config write.
`timescale 1ns / 1ps
`default_nettype none

interface rpwd_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

interface rpwd_out_if
    import rpwd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              duty_valid;
    logic [DUTY_W-1:0] duty_value;
    logic [TICK_W-1:0] pulse_width;
    logic              timed_out;

    modport source (output valid, output duty_valid, output duty_value,
                    output pulse_width, output timed_out, input ready);
    modport sink   (input valid, input duty_valid, input duty_value,
                    input pulse_width, input timed_out, output ready);
endinterface

interface rpwd_cfg_if
    import rpwd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rpwd_out_fifo.sv =====
// Small result queue that drives the output channel.
`timescale 1ns / 1ps
`default_nettype none

module rpwd_out_fifo
    import rpwd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire result_t wr_data,
    rpwd_out_if.source   duty_out
);

    result_t           mem [QUEUE_DEPTH];
    logic [QPTR_W:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W:0]   rd_ptr_reg, rd_ptr_next;
    logic              empty;
    logic              pop;
    result_t           head;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign pop   = duty_out.valid && duty_out.ready;
    assign head  = mem[rd_ptr_reg[QPTR_W-1:0]];

    assign duty_out.valid       = !empty;
    assign duty_out.duty_valid  = head.duty_valid;
    assign duty_out.duty_value  = head.duty_value;
    assign duty_out.pulse_width = head.pulse_width;
    assign duty_out.timed_out   = head.timed_out;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop   ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg[QPTR_W-1:0]] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rc_pulse_width_decoder_top.sv =====
// Top level of the RC pulse width decoder: edge timing, scaling pipeline, result queue.
//
// Usage:
//   pulse_in carries one word per microsecond tick: the sampled pin level.
//   Every accepted word yields exactly one word on duty_out, in order.
//   duty_out reports a new duty value and the raw high time on a falling
//   edge, and the signal loss flag on every tick.
//   cfg writes register 0 (max_duty, low 16 bits of data) or register 1
//   (timeout_ticks); cfg.ready is always high. Write only while idle.
// Timing:
//   One word accepted per cycle. Edge detection and clamping happen at
//   acceptance; the scaled duty takes a multiply stage by max_duty and a
//   reciprocal multiply stage for the divide by the pulse range, then a
//   remainder correction into the queue.
//   pulse_in.ready comes from an occupancy counter over the pipeline and an
//   8-word output queue, so a stalled receiver never drops or repeats words;
//   input stalls once 8 words are outstanding.
// Reset:
//   rst_n clears the tick counter, edge state, pipeline and queue, and loads
//   max_duty = 1023 and timeout_ticks = 1000000.
`timescale 1ns / 1ps
`default_nettype none

module rc_pulse_width_decoder_top
    import rpwd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rpwd_in_if.sink   pulse_in,
    rpwd_out_if.source duty_out,
    rpwd_cfg_if.sink  cfg
);

    // Configuration
    logic [DUTY_W-1:0] max_duty_reg;
    logic [TICK_W-1:0] timeout_ticks_reg;

    // Edge tracking state
    logic              prev_level_reg;
    logic [TICK_W-1:0] tick_count_reg;
    logic [TICK_W-1:0] rise_time_reg;
    logic              seen_rise_reg;
    logic [TICK_W-1:0] since_rise_reg;

    logic              prev_level_next;
    logic [TICK_W-1:0] tick_count_next;
    logic [TICK_W-1:0] rise_time_next;
    logic              seen_rise_next;
    logic [TICK_W-1:0] since_rise_next;

    logic              accept;
    logic              pop;
    logic              rise;
    logic              fall;
    logic [TICK_W-1:0] width;
    logic [TICK_W-1:0] clamped;
    logic              lost;

    // Pipeline stages
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic              s1_fall_reg, s2_fall_reg, s3_fall_reg;
    logic              s1_lost_reg, s2_lost_reg, s3_lost_reg;
    logic [TICK_W-1:0] s1_width_reg, s2_width_reg, s3_width_reg;
    logic [OFF_W-1:0]  s1_off_reg;
    logic [PROD_W-1:0] s2_prod_reg, s3_prod_reg;
    logic [DUTY_W-1:0] s3_quot_reg;

    logic [PROD_W+RECIP_W-1:0] recip_prod;
    logic [PROD_W-1:0]         quot_times_range;
    logic [PROD_W-1:0]         remainder;
    logic [DUTY_W-1:0]         quot;
    result_t                   result;

    logic [QPTR_W:0]   occ_reg, occ_next;

    assign accept         = pulse_in.valid && pulse_in.ready;
    assign pop            = duty_out.valid && duty_out.ready;
    assign pulse_in.ready = (occ_reg < (QPTR_W+1)'(QUEUE_DEPTH));
    assign cfg.ready      = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_duty_reg      <= MAX_DUTY_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_MAX_DUTY:      max_duty_reg      <= cfg.data[DUTY_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg.data[TICK_W-1:0];
                default:           ;
            endcase
        end
    end

    // Edge detection and state update for the accepted tick
    always_comb
    begin
        rise = pulse_in.pin_level && !prev_level_reg;
        fall = !pulse_in.pin_level && prev_level_reg;

        rise_time_next  = rise_time_reg;
        seen_rise_next  = seen_rise_reg;
        since_rise_next = since_rise_reg;
        if (rise)
        begin
            rise_time_next  = tick_count_reg;
            seen_rise_next  = 1'b1;
            since_rise_next = '0;
        end
        else if (seen_rise_reg && (since_rise_reg != '1))
        begin
            since_rise_next = since_rise_reg + 1'b1;
        end

        prev_level_next = pulse_in.pin_level;
        tick_count_next = tick_count_reg + 1'b1;

        lost  = seen_rise_next && (since_rise_next > timeout_ticks_reg);
        width = tick_count_reg - rise_time_reg;

        if (width < PULSE_MIN_T)
            clamped = PULSE_MIN_T;
        else if (width > PULSE_MAX_T)
            clamped = PULSE_MAX_T;
        else
            clamped = width;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            tick_count_reg <= '0;
            rise_time_reg  <= '0;
            seen_rise_reg  <= 1'b0;
            since_rise_reg <= '0;
        end
        else if (accept)
        begin
            prev_level_reg <= prev_level_next;
            tick_count_reg <= tick_count_next;
            rise_time_reg  <= rise_time_next;
            seen_rise_reg  <= seen_rise_next;
            since_rise_reg <= since_rise_next;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_fall_reg  <= fall;
        s1_lost_reg  <= lost;
        s1_width_reg <= fall ? width : '0;
        s1_off_reg   <= OFF_W'(clamped - PULSE_MIN_T);

        s2_fall_reg  <= s1_fall_reg;
        s2_lost_reg  <= s1_lost_reg;
        s2_width_reg <= s1_width_reg;
        s2_prod_reg  <= PROD_W'(s1_off_reg) * PROD_W'(max_duty_reg);

        s3_fall_reg  <= s2_fall_reg;
        s3_lost_reg  <= s2_lost_reg;
        s3_width_reg <= s2_width_reg;
        s3_prod_reg  <= s2_prod_reg;
        s3_quot_reg  <= recip_prod[PROD_W +: DUTY_W];
    end

    // Estimate is low by at most one
    assign recip_prod = (PROD_W+RECIP_W)'(s2_prod_reg) * (PROD_W+RECIP_W)'(RECIP);

    // Remainder check fixes the quotient estimate
    always_comb
    begin
        quot_times_range = PROD_W'(s3_quot_reg) * PROD_W'(PULSE_RANGE);
        remainder        = s3_prod_reg - quot_times_range;
        if (remainder >= PROD_W'(PULSE_RANGE))
            quot = s3_quot_reg + 1'b1;
        else
            quot = s3_quot_reg;

        result.duty_valid  = s3_fall_reg;
        result.pulse_width = s3_width_reg;
        result.timed_out   = s3_lost_reg;
        if (!s3_fall_reg)
            result.duty_value = '0;
        else if (PULSE_DEGEN)
            result.duty_value = max_duty_reg;
        else
            result.duty_value = quot;
    end

    // Words accepted but not yet delivered
    always_comb
    begin
        occ_next = occ_reg;
        if (accept && !pop)
            occ_next = occ_reg + 1'b1;
        else if (!accept && pop)
            occ_next = occ_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    rpwd_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (s3_valid_reg),
        .wr_data  (result),
        .duty_out (duty_out)
    );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the RC pulse width decoder: random pulse trains checked per tick.
`timescale 1ns / 1ps

module tb;
    import rpwd_pkg::*;

    localparam int unsigned IDLE_LIMIT  = 5000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned HOLD_AT     = 300;
    localparam int unsigned DRAIN_WAIT  = 20;
    localparam int unsigned NO_GAP_FROM = 800;
    localparam int unsigned NO_GAP_TO   = 1300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rpwd_in_if  pulse_in();
    rpwd_out_if duty_out();
    rpwd_cfg_if cfg();

    rc_pulse_width_decoder_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pulse_in (pulse_in),
        .duty_out (duty_out),
        .cfg      (cfg)
    );

    always #5 clk = ~clk;

    bit          pin_levels_q[$];
    result_t     duty_expect_q[$];
    int unsigned ticks_queued = 0;
    int unsigned ticks_taken = 0;
    int unsigned words_checked = 0;
    int unsigned edges_seen = 0;
    int unsigned timeouts_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_no = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          pulse_taken = 1'b0;
    logic        no_gaps;

    // decoder shadow: edge state and register copies
    logic              lvl_prev = 1'b0;
    logic              rise_seen = 1'b0;
    logic [TICK_W-1:0] now_tick = '0;
    logic [TICK_W-1:0] rise_tick = '0;
    logic [TICK_W-1:0] since_rise_t = '0;
    logic [DUTY_W-1:0] max_duty_r = MAX_DUTY_RST;
    logic [TICK_W-1:0] timeout_r = TIMEOUT_TICKS_RST;

    assign no_gaps = (cycle_no >= NO_GAP_FROM) && (cycle_no < NO_GAP_TO);

    function automatic logic [DUTY_W-1:0] scale_duty(logic [TICK_W-1:0] width);
        logic [TICK_W-1:0] w;
        longint unsigned   prod;
        if (PULSE_MAX <= PULSE_MIN)
            return max_duty_r;
        w = width;
        if (w < PULSE_MIN_T)
            w = PULSE_MIN_T;
        if (w > PULSE_MAX_T)
            w = PULSE_MAX_T;
        prod = 64'(w - PULSE_MIN_T) * 64'(max_duty_r);
        return DUTY_W'(prod / 64'(PULSE_MAX - PULSE_MIN));
    endfunction

    function automatic result_t next_tick(logic level);
        result_t r;
        r = '0;
        if (level && !lvl_prev)
        begin
            rise_tick = now_tick;
            rise_seen = 1'b1;
            since_rise_t = '0;
        end
        else
        begin
            if (rise_seen && since_rise_t != '1)
                since_rise_t = since_rise_t + 1'b1;
            if (!level && lvl_prev)
            begin
                r.pulse_width = now_tick - rise_tick;
                r.duty_value = scale_duty(r.pulse_width);
                r.duty_valid = 1'b1;
            end
        end
        r.timed_out = rise_seen && (since_rise_t > timeout_r);
        lvl_prev = level;
        now_tick = now_tick + 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [TICK_W-1:0] got_v,
                                   logic [TICK_W-1:0] want_v);
        mismatches++;
        $display("mismatch at word %0d: %s got %0h expected %0h",
                 words_checked, field, got_v, want_v);
    endtask

    task automatic queue_pulse(int unsigned high_ticks, int unsigned low_ticks);
        repeat (high_ticks) pin_levels_q.push_back(1'b1);
        repeat (low_ticks) pin_levels_q.push_back(1'b0);
        ticks_queued += high_ticks + low_ticks;
    endtask

    // Short pulses; optionally one long pulse around the bottom clamp limit first.
    task automatic queue_random_phase(int unsigned n_items, bit with_long);
        int unsigned start;
        int unsigned high_t;
        int unsigned low_t;
        start = ticks_queued;
        if (with_long)
        begin
            case ($urandom_range(3, 0))
                0:       high_t = PULSE_MIN - 1;
                1:       high_t = PULSE_MIN;
                2:       high_t = PULSE_MIN + 1;
                default: high_t = $urandom_range(PULSE_MIN + 150, PULSE_MIN + 2);
            endcase
            queue_pulse(high_t, $urandom_range(30, 1));
        end
        while (ticks_queued - start < n_items)
        begin
            high_t = $urandom_range(40, 1);
            // occasional longer low stretch to run past short timeouts
            if ($urandom_range(99, 0) < 8)
                low_t = $urandom_range(120, 40);
            else
                low_t = $urandom_range(30, 1);
            queue_pulse(high_t, low_t);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pin_levels_q.size() != 0 || ticks_taken != ticks_queued
               || duty_expect_q.size() != 0);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!(cfg.valid && cfg.ready));
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // pin sample driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pulse_in.valid <= 1'b0;
            pulse_in.pin_level <= 1'b0;
        end
        else if (!pulse_in.valid || pulse_taken)
        begin
            if (pin_levels_q.size() != 0 && (no_gaps || $urandom_range(99, 0) >= 10))
            begin
                pulse_in.valid <= 1'b1;
                pulse_in.pin_level <= pin_levels_q.pop_front();
            end
            else
            begin
                pulse_in.valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back up the output queue
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            duty_out.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            duty_out.ready <= 1'b0;
        end
        else if (!hold_done && words_checked >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            duty_out.ready <= 1'b0;
        end
        else
        begin
            duty_out.ready <= no_gaps || ($urandom_range(99, 0) >= 10);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            cycle_no++;
            pulse_taken <= pulse_in.valid && pulse_in.ready;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_MAX_DUTY:      max_duty_r = cfg.data[DUTY_W-1:0];
                    CFG_TIMEOUT_TICKS: timeout_r = cfg.data;
                    default:           ;
                endcase
            end

            if (pulse_in.valid && pulse_in.ready)
            begin
                duty_expect_q.push_back(next_tick(pulse_in.pin_level));
                ticks_taken++;
            end

            if (duty_out.valid && duty_out.ready)
            begin
                got.duty_valid  = duty_out.duty_valid;
                got.duty_value  = duty_out.duty_value;
                got.pulse_width = duty_out.pulse_width;
                got.timed_out   = duty_out.timed_out;
                if (duty_expect_q.size() == 0)
                begin
                    report_mismatch("word with nothing pending", got.pulse_width, '0);
                end
                else
                begin
                    want = duty_expect_q.pop_front();
                    if (got.duty_valid !== want.duty_valid)
                        report_mismatch("duty_valid", TICK_W'(got.duty_valid),
                                        TICK_W'(want.duty_valid));
                    if (got.duty_value !== want.duty_value)
                        report_mismatch("duty_value", TICK_W'(got.duty_value),
                                        TICK_W'(want.duty_value));
                    if (got.pulse_width !== want.pulse_width)
                        report_mismatch("pulse_width", got.pulse_width, want.pulse_width);
                    if (got.timed_out !== want.timed_out)
                        report_mismatch("timed_out", TICK_W'(got.timed_out),
                                        TICK_W'(want.timed_out));
                    if (want.duty_valid)
                        edges_seen++;
                    if (want.timed_out)
                        timeouts_seen++;
                end
                words_checked++;
            end

            if ((pulse_in.valid && pulse_in.ready) || (duty_out.valid && duty_out.ready)
                || (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        bit [23:0] warmup;
        warmup = 24'b0010_1100_1111_1000_1011_0100;
        pulse_in.valid = 1'b0;
        pulse_in.pin_level = 1'b0;
        duty_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_MAX_DUTY;
        cfg.data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: short pulses, all clamped to the bottom
        for (int i = 23; i >= 0; i--)
        begin
            pin_levels_q.push_back(warmup[i]);
            ticks_queued++;
        end
        queue_random_phase(80, 1'b0);
        wait_drained();

        // full scale duty with one long pulse near the bottom clamp
        write_reg(CFG_MAX_DUTY, 32'hFFFF_FFFF);
        write_reg(CFG_TIMEOUT_TICKS, 32'd1);
        queue_random_phase(80, 1'b1);
        wait_drained();

        write_reg(CFG_MAX_DUTY, 32'h0000_0000);
        write_reg(CFG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
        queue_random_phase(80, 1'b0);
        wait_drained();

        write_reg(CFG_MAX_DUTY, $urandom());
        write_reg(CFG_TIMEOUT_TICKS, $urandom_range(60, 2));
        queue_random_phase(80, 1'b0);
        wait_drained();

        // timeout shorter than the longer low gaps
        write_reg(CFG_MAX_DUTY, 32'd1);
        write_reg(CFG_TIMEOUT_TICKS, 32'd40);
        queue_random_phase(80, 1'b0);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge clk);

        if (duty_expect_q.size() != 0)
            report_mismatch("words never produced", TICK_W'(duty_expect_q.size()), '0);
        $display("covered %0d ticks, %0d falling edges, %0d timed-out ticks, 5 register settings",
                 ticks_taken, edges_seen, timeouts_seen);
        $display("%0d words checked, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rpwd_pkg.sv
hdl/rpwd_intf.sv
hdl/rpwd_out_fifo.sv
hdl/rc_pulse_width_decoder_top.sv
verif/tb.sv
